// ----- hw/rtl/steering_angle_converter_macros.svh -----
// assertion macros for the steering angle converter
// used by the top level only; needs clk_i and rst_ni in the including scope
`ifndef STEERING_ANGLE_CONVERTER_MACROS_SVH
`define STEERING_ANGLE_CONVERTER_MACROS_SVH

// same-cycle implication
`define SAC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sac assertion failed");

// next-cycle implication
`define SAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sac assertion failed");

`endif

// ----- hw/rtl/sac_pkg.sv -----
// shared types and constants of the steering angle converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

  localparam int ANGLE_W = 16;
  localparam int DZ_W    = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  typedef enum logic [1:0] {
    ST_VALID          = 2'd0,
    ST_SAMPLE_INVALID = 2'd1,
    ST_CONFIG_INVALID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_ZERO_RAW       = 3'd0,
    REG_POSITIVE_RAW   = 3'd1,
    REG_NEGATIVE_RAW   = 3'd2,
    REG_POSITIVE_ANGLE = 3'd3,
    REG_NEGATIVE_ANGLE = 3'd4,
    REG_DEADZONE_WIDTH = 3'd5
  } reg_idx_e;

  typedef struct packed {
    status_e status;
    logic    side_pos;
  } ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sac_fifo.sv -----
// small synchronous fifo used between the stages of the converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0]      wptr_q, wptr_d;
  logic [AW:0]      rptr_q, rptr_d;
  logic             wr_en, rd_en;

  assign full_o  = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
  assign empty_o = (wptr_q == rptr_q);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q[AW-1:0]];

  assign wptr_d = wr_en ? wptr_q + (AW+1)'(1) : wptr_q;
  assign rptr_d = rd_en ? rptr_q + (AW+1)'(1) : rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sac_front.sv -----
// front end: takes samples, recentres them, classifies and forms the products
// depends on sac_pkg
`timescale 1ns / 1ps
`default_nettype none

module sac_front #(
  parameter int SB = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [SB-1:0]                 sample_i,
  input  wire logic                          ready_i,
  input  wire logic [SB-1:0]                 zero_raw_i,
  input  wire logic [SB-1:0]                 positive_raw_i,
  input  wire logic [SB-1:0]                 negative_raw_i,
  input  wire logic [sac_pkg::ANGLE_W-1:0]   positive_angle_i,
  input  wire logic [sac_pkg::ANGLE_W-1:0]   negative_angle_i,
  input  wire logic [sac_pkg::DZ_W-1:0]      deadzone_width_i,
  output logic                               valid_o,
  output sac_pkg::ctl_t                      ctl_o,
  output logic [SB+sac_pkg::ANGLE_W+1:0]     prod_o,
  output logic [SB+sac_pkg::DZ_W-1:0]        dzden_o,
  output logic [SB-1:0]                      den_o
);

  import sac_pkg::*;

  localparam int PW = SB + ANGLE_W + 2;
  localparam int DW = SB + DZ_W;
  localparam logic [SB-1:0] HALF = SB'(1) << (SB - 1);

  logic [SB-1:0] s, pos_s, neg_s;
  logic          cfg_bad, out_range, side_pos;

  ctl_t                     ctl_a_d, ctl_a_q;
  logic [SB-1:0]            d_a_d, d_a_q, den_a_d, den_a_q;
  logic signed [ANGLE_W:0]  a_a_d, a_a_q;
  logic                     vld_a_q, vld_b_q;

  ctl_t                     ctl_b_q;
  logic signed [PW-1:0]     prod_b_d, prod_b_q;
  logic [DW-1:0]            dzden_b_d, dzden_b_q;
  logic [SB-1:0]            den_b_q;

  // recentre so that the calibrated zero lands on half scale
  assign s     = sample_i - zero_raw_i + HALF;
  assign pos_s = positive_raw_i - zero_raw_i + HALF;
  assign neg_s = negative_raw_i - zero_raw_i + HALF;

  assign cfg_bad   = (neg_s >= HALF) || (pos_s <= HALF);
  assign out_range = (s < neg_s) || (s > pos_s);
  assign side_pos  = (s > HALF);

  always_comb begin
    ctl_a_d.side_pos = side_pos;
    if (cfg_bad) begin
      ctl_a_d.status = ST_CONFIG_INVALID;
    end else if (out_range) begin
      ctl_a_d.status = ST_SAMPLE_INVALID;
    end else begin
      ctl_a_d.status = ST_VALID;
    end
    if (side_pos) begin
      d_a_d   = s - HALF;
      den_a_d = pos_s - HALF;
      a_a_d   = $signed({positive_angle_i[ANGLE_W-1], positive_angle_i});
    end else begin
      d_a_d   = HALF - s;
      den_a_d = HALF - neg_s;
      a_a_d   = -$signed({negative_angle_i[ANGLE_W-1], negative_angle_i});
    end
  end

  // magnitude-side product; positive when the angle points away from zero
  assign prod_b_d  = PW'($signed({1'b0, d_a_q})) * PW'(a_a_q);
  assign dzden_b_d = DW'(deadzone_width_i) * DW'(den_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (ready_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i) begin
      ctl_a_q   <= ctl_a_d;
      d_a_q     <= d_a_d;
      den_a_q   <= den_a_d;
      a_a_q     <= a_a_d;
      ctl_b_q   <= ctl_a_q;
      prod_b_q  <= prod_b_d;
      dzden_b_q <= dzden_b_d;
      den_b_q   <= den_a_q;
    end
  end

  assign valid_o = vld_b_q;
  assign ctl_o   = ctl_b_q;
  assign prod_o  = prod_b_q;
  assign dzden_o = dzden_b_q;
  assign den_o   = den_b_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sac_back.sv -----
// back end: deadzone test and pipelined restoring divider, one quotient bit a stage
// depends on sac_pkg
`timescale 1ns / 1ps
`default_nettype none

module sac_back #(
  parameter int SB = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          ready_i,
  input  wire logic                          valid_i,
  input  wire sac_pkg::ctl_t                 ctl_i,
  input  wire logic [SB+sac_pkg::ANGLE_W+1:0] prod_i,
  input  wire logic [SB+sac_pkg::DZ_W-1:0]   dzden_i,
  input  wire logic [SB-1:0]                 den_i,
  output logic                               valid_o,
  output logic [sac_pkg::ANGLE_W-1:0]        angle_o,
  output logic [1:0]                         status_o
);

  import sac_pkg::*;

  localparam int PW = SB + ANGLE_W + 2;
  localparam int CW = PW + 1;
  localparam int QW = ANGLE_W;
  localparam int RW = SB + QW;

  logic            dz_hit, kill0;
  logic [QW:0]     vld_q;
  logic [RW-1:0]   rem_q [QW+1];
  logic [QW-1:0]   quo_q [QW+1];
  logic [SB-1:0]   den_q [QW+1];
  ctl_t            ctl_q [QW+1];
  logic            kill_q [QW+1];
  logic [QW-1:0]   quo;

  assign dz_hit = $signed({prod_i, 1'b0}) <= $signed(CW'(dzden_i));
  assign kill0  = (ctl_i.status != ST_VALID) || dz_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ready_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i) begin
      rem_q[0]  <= prod_i[RW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      ctl_q[0]  <= ctl_i;
      kill_q[0] <= kill0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = RW'(den_q[j]) << K;
    assign ge    = (rem_q[j] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (ready_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready_i) begin
        rem_q[j+1]  <= ge ? rem_q[j] - trial : rem_q[j];
        quo_q[j+1]  <= quo_q[j] | (ge ? (QW'(1) << K) : '0);
        den_q[j+1]  <= den_q[j];
        ctl_q[j+1]  <= ctl_q[j];
        kill_q[j+1] <= kill_q[j];
      end
    end
  end

  assign quo      = quo_q[QW];
  assign valid_o  = vld_q[QW];
  assign status_o = ctl_q[QW].status;

  always_comb begin
    if (kill_q[QW]) begin
      angle_o = '0;
    end else if (ctl_q[QW].side_pos) begin
      angle_o = quo;
    end else begin
      angle_o = -quo;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/steering_angle_converter.sv -----
// Steering angle converter top level: configuration registers, front end,
// item queue, divider back end and result queue.
// Depends on sac_pkg, sac_fifo, sac_front, sac_back and the macro header.
//
// Usage:
//   Samples enter on raw_sample_i, taken when push is high and full is low.
//   Results leave on angle_o / status_o while empty is low, taken with pop.
//   One result per sample, in order. Sustained rate is one item per cycle
//   while pop keeps up; an accepted sample passes the two front stages (the
//   first loaded at the accepting edge), the item queue, the one-bit-per-stage
//   divider and the result queue.
//   When pop stays low the result queue fills, the divider freezes, the item
//   queue fills and full rises; nothing is dropped.
//   The APB port writes and reads the six calibration registers at byte
//   addresses 0 to 20; write them only while no item is in flight.
//   Reset empties both queues, clears all stage valids and loads the
//   straight-ahead calibration: zero 2048, ends 4095 / 0, angles +/-9000,
//   no deadzone.
`timescale 1ns / 1ps
`default_nettype none
`include "steering_angle_converter_macros.svh"

module steering_angle_converter #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  input  wire logic [SAMPLE_BITS-1:0]      raw_sample_i,
  output logic                             full,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [sac_pkg::ANGLE_W-1:0]      angle_o,
  output logic [1:0]                       status_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sac_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sac_pkg::DATA_W-1:0]  pwdata,
  output logic [sac_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  import sac_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + ANGLE_W + 2;
  localparam int DW = SB + DZ_W;
  localparam int CTL_W = $bits(ctl_t);
  localparam int MW = CTL_W + PW + DW + SB;
  localparam int OW = ANGLE_W + 2;
  localparam logic [SB-1:0] ZERO_RST = SB'(2048 % (2 ** SB));

  logic [SB-1:0]      zero_raw_q, positive_raw_q, negative_raw_q;
  logic [ANGLE_W-1:0] positive_angle_q, negative_angle_q;
  logic [DZ_W-1:0]    deadzone_width_q;
  logic               cfg_we;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_raw_q       <= ZERO_RST;
      positive_raw_q   <= '1;
      negative_raw_q   <= '0;
      positive_angle_q <= ANGLE_W'(9000);
      negative_angle_q <= ANGLE_W'(-9000);
      deadzone_width_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ZERO_RAW:       zero_raw_q       <= pwdata[SB-1:0];
        REG_POSITIVE_RAW:   positive_raw_q   <= pwdata[SB-1:0];
        REG_NEGATIVE_RAW:   negative_raw_q   <= pwdata[SB-1:0];
        REG_POSITIVE_ANGLE: positive_angle_q <= pwdata[ANGLE_W-1:0];
        REG_NEGATIVE_ANGLE: negative_angle_q <= pwdata[ANGLE_W-1:0];
        REG_DEADZONE_WIDTH: deadzone_width_q <= pwdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ZERO_RAW:       prdata = DATA_W'(zero_raw_q);
      REG_POSITIVE_RAW:   prdata = DATA_W'(positive_raw_q);
      REG_NEGATIVE_RAW:   prdata = DATA_W'(negative_raw_q);
      REG_POSITIVE_ANGLE: prdata = DATA_W'(positive_angle_q);
      REG_NEGATIVE_ANGLE: prdata = DATA_W'(negative_angle_q);
      REG_DEADZONE_WIDTH: prdata = DATA_W'(deadzone_width_q);
      default:            prdata = '0;
    endcase
  end

  logic          fr_valid, fr_ready;
  ctl_t          fr_ctl;
  logic [PW-1:0] fr_prod;
  logic [DW-1:0] fr_dzden;
  logic [SB-1:0] fr_den;

  logic          mq_full, mq_empty, mq_pop;
  logic [MW-1:0] mq_rdata;
  ctl_t          mq_ctl;
  logic [PW-1:0] mq_prod;
  logic [DW-1:0] mq_dzden;
  logic [SB-1:0] mq_den;

  logic               bk_ready, bk_valid, of_full;
  logic [ANGLE_W-1:0] bk_angle;
  logic [1:0]         bk_status;
  logic [OW-1:0]      of_rdata;

  assign fr_ready = !mq_full;
  assign full     = mq_full;

  sac_front #(.SB(SB)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (push),
    .sample_i         (raw_sample_i),
    .ready_i          (fr_ready),
    .zero_raw_i       (zero_raw_q),
    .positive_raw_i   (positive_raw_q),
    .negative_raw_i   (negative_raw_q),
    .positive_angle_i (positive_angle_q),
    .negative_angle_i (negative_angle_q),
    .deadzone_width_i (deadzone_width_q),
    .valid_o          (fr_valid),
    .ctl_o            (fr_ctl),
    .prod_o           (fr_prod),
    .dzden_o          (fr_dzden),
    .den_o            (fr_den)
  );

  sac_fifo #(.WIDTH(MW), .DEPTH(4)) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid && fr_ready),
    .wdata_i ({fr_ctl, fr_prod, fr_dzden, fr_den}),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .rdata_o (mq_rdata),
    .empty_o (mq_empty)
  );

  assign {mq_ctl, mq_prod, mq_dzden, mq_den} = mq_rdata;
  assign bk_ready = !of_full;
  assign mq_pop   = bk_ready && !mq_empty;

  sac_back #(.SB(SB)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ready_i  (bk_ready),
    .valid_i  (!mq_empty),
    .ctl_i    (mq_ctl),
    .prod_i   (mq_prod),
    .dzden_i  (mq_dzden),
    .den_i    (mq_den),
    .valid_o  (bk_valid),
    .angle_o  (bk_angle),
    .status_o (bk_status)
  );

  sac_fifo #(.WIDTH(OW), .DEPTH(2)) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_valid && bk_ready),
    .wdata_i ({bk_angle, bk_status}),
    .full_o  (of_full),
    .pop_i   (pop),
    .rdata_o (of_rdata),
    .empty_o (empty)
  );

  assign {angle_o, status_o} = of_rdata;

  `SAC_ASSERT_NOW(a_invalid_zero, !empty && (status_o != ST_VALID), angle_o == '0)
  `SAC_ASSERT_NOW(a_front_no_overflow, fr_valid && fr_ready, !mq_full)
  `SAC_ASSERT_NEXT(a_back_holds_on_stall, bk_valid && of_full, bk_valid)

endmodule

`default_nettype wire
